FILE: sv/dtle_pkg.sv
// ----------------------------------------------------------------------------
// dtle_pkg - shared types and constants for the title line extractor
// Keyword bytes, prefix fallback table, character codes, op and kind codes,
// and the keyword step function used by the scanner.
// ----------------------------------------------------------------------------
package dtle_pkg;

   // title capacity and derived store geometry
   localparam int TITLE_CHARS = 32;
   localparam int ADDR_W      = (TITLE_CHARS > 1) ? $clog2(TITLE_CHARS) : 1;

   // field widths
   localparam int OP_W       = 2;
   localparam int CHAR_W     = 8;
   localparam int LEN_W      = 6;
   localparam int KIND_W     = 2;
   localparam int RSP_DATA_W = 16;   // char_out + title_len, padded to bytes

   // keyword "%%Title:"
   localparam int KEY_LEN   = 8;
   localparam int KEY_IDX_W = 3;
   localparam int KEY_W     = 4;     // match count, can hold KEY_LEN

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [KEY_W-1:0]  key_cnt_type;

   localparam char_type KEY_BYTES [KEY_LEN] = '{
      8'h25, 8'h25, 8'h54, 8'h69, 8'h74, 8'h6C, 8'h65, 8'h3A
   };

   // longest proper prefix that is also a suffix of key[0..k]
   localparam key_cnt_type KEY_FAIL [KEY_LEN] = '{
      4'd0, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
   };

   // characters of interest
   localparam char_type CH_SPACE  = 8'h20;
   localparam char_type CH_TAB    = 8'h09;
   localparam char_type CH_LPAREN = 8'h28;
   localparam char_type CH_RPAREN = 8'h29;
   localparam char_type CH_QUOTE  = 8'h22;
   localparam char_type CH_CR     = 8'h0D;
   localparam char_type CH_LF     = 8'h0A;

   typedef enum logic [OP_W-1:0] {
      OP_DATA   = 2'd0,
      OP_START  = 2'd1,
      OP_FINISH = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPT = 2'd0,
      KIND_CHAR   = 2'd1,
      KIND_END    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PH_SEARCH  = 3'b001,
      PH_COLLECT = 3'b010,
      PH_DONE    = 3'b100
   } phase_type;

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_TRIM_RD  = 5'b00010,
      ST_TRIM_CHK = 5'b00100,
      ST_EMIT_RD  = 5'b01000,
      ST_EMIT_OUT = 5'b10000
   } state_type;

   // One keyword step: fall back along the prefix table on a mismatch,
   // then advance on a match. Returns KEY_LEN when the keyword completes.
   function automatic key_cnt_type match_next(input key_cnt_type k_in,
                                              input char_type    c);
      key_cnt_type k;
      k = (k_in >= key_cnt_type'(KEY_LEN)) ? '0 : k_in;
      for (int s = 0; s < KEY_LEN; s++) begin
         if (k != '0 && c != KEY_BYTES[k[KEY_IDX_W-1:0]]) begin
            k = KEY_FAIL[k[KEY_IDX_W-1:0] - KEY_IDX_W'(1)];
         end
      end
      if (c == KEY_BYTES[k[KEY_IDX_W-1:0]]) begin
         k = k + key_cnt_type'(1);
      end
      return k;
   endfunction

endpackage

FILE: sv/dtle_ram.sv
// ----------------------------------------------------------------------------
// dtle_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module dtle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/dsc_title_line_extractor_top.sv
// ----------------------------------------------------------------------------
// dsc_title_line_extractor_top - keyword scan and title line capture
// Watches a byte stream for "%%Title:", collects the rest of that line into
// a small RAM, trims it, and streams it back as a run of character words.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+-------------------------------------
//   req     | in  | req_tvalid/req_tready| tuser = op, tdata = byte_req
//   rsp     | out | rsp_tvalid/rsp_tready| tuser = kind, tdata = char_out,
//           |     |                      |   title_len; tlast = last
//
// A plain data, start or unused word yields one accept word. A line end or
// finish op walks the title RAM instead: a line end first trims trailing
// spaces, close parens and quotes (a finish op skips the trim), then emission
// sends each title character and closes with the end word; the single
// registered RAM read port paces both walks.
// Synchronous active-high reset clears the scanner; the title RAM is not
// cleared, only entries below the held length are ever read.
// A stalled rsp side holds the output register, and the sequencer waits before each output word.
// ----------------------------------------------------------------------------
module dsc_title_line_extractor_top (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: [7:0] byte_req
   input  logic [dtle_pkg::CHAR_W-1:0]       req_tdata,
   // req_tuser: [1:0] op
   input  logic [dtle_pkg::OP_W-1:0]         req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // rsp_tdata: [7:0] char_out, [13:8] title_len, [15:14] zero
   output logic [dtle_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // rsp_tuser: [1:0] kind
   output logic [dtle_pkg::KIND_W-1:0]       rsp_tuser,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready
);

   import dtle_pkg::*;

   // sequencer and scanner state
   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in;
   key_cnt_type         match_ff, match_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [LEN_W-1:0]    idx_ff, idx_in;
   logic                clear_after_ff, clear_after_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            rsp_kind_ff, rsp_kind_in;
   char_type            rsp_char_ff, rsp_char_in;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;
   logic                rsp_last_ff, rsp_last_in;

   // title RAM ports
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [ADDR_W-1:0]   ram_rd_addr;
   char_type            ram_rd_data;

   logic                out_free;
   logic                accept;
   char_type            in_char;
   key_cnt_type         key_step;
   logic [LEN_W-1:0]    len_m1;

   dtle_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (TITLE_CHARS)
   ) u_title_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (in_char),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign in_char  = req_tdata;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept   = req_tvalid && req_tready;
   assign key_step = match_next(match_ff, in_char);
   assign len_m1   = len_ff - LEN_W'(1);

   // trim reads the tail character, emission reads at the running index
   assign ram_rd_addr = (state_ff == ST_TRIM_RD || state_ff == ST_TRIM_CHK) ?
                        len_m1[ADDR_W-1:0] : idx_ff[ADDR_W-1:0];
   assign ram_wr_addr = len_ff[ADDR_W-1:0];

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      match_in       = match_ff;
      len_in         = len_ff;
      idx_in         = idx_ff;
      clear_after_in = clear_after_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_char_in    = rsp_char_ff;
      rsp_len_in     = rsp_len_ff;
      rsp_last_in    = rsp_last_ff;
      ram_wr_en      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // default answer: one accept word; line end and finish override
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ACCEPT;
               rsp_char_in  = '0;
               rsp_len_in   = '0;
               rsp_last_in  = 1'b1;
               case (op_type'(req_tuser))
                  OP_START: begin
                     phase_in = PH_SEARCH;
                     match_in = '0;
                     len_in   = '0;
                  end
                  OP_FINISH: begin
                     // emit the title as held, then clear the scanner
                     rsp_valid_in   = rsp_valid_ff && !rsp_tready;
                     clear_after_in = 1'b1;
                     idx_in         = '0;
                     state_in       = ST_EMIT_RD;
                  end
                  OP_DATA: begin
                     case (phase_ff)
                        PH_SEARCH: begin
                           if (key_step == key_cnt_type'(KEY_LEN)) begin
                              phase_in = PH_COLLECT;
                              match_in = '0;
                           end else begin
                              match_in = key_step;
                           end
                        end
                        PH_COLLECT: begin
                           if (in_char == CH_CR || in_char == CH_LF) begin
                              // line end: trim, then emit in place of the accept word
                              rsp_valid_in   = rsp_valid_ff && !rsp_tready;
                              phase_in       = PH_DONE;
                              clear_after_in = 1'b0;
                              state_in       = ST_TRIM_RD;
                           end else if (len_ff == '0 &&
                                        (in_char == CH_SPACE || in_char == CH_TAB ||
                                         in_char == CH_LPAREN || in_char == CH_QUOTE)) begin
                              // drop leading filler
                           end else if (len_ff < LEN_W'(TITLE_CHARS)) begin
                              ram_wr_en = 1'b1;
                              len_in    = len_ff + LEN_W'(1);
                           end
                        end
                        default: begin
                           // line already ended: ignore the byte
                        end
                     endcase
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_TRIM_RD: begin
            // tail address is on the read port; data shows next cycle
            if (len_ff == '0) begin
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_TRIM_CHK;
            end
         end

         ST_TRIM_CHK: begin
            if (ram_rd_data == CH_SPACE || ram_rd_data == CH_RPAREN ||
                ram_rd_data == CH_QUOTE) begin
               len_in   = len_m1;
               state_in = ST_TRIM_RD;
            end else begin
               idx_in   = '0;
               state_in = ST_EMIT_RD;
            end
         end

         ST_EMIT_RD: begin
            if (idx_ff == len_ff) begin
               // close the run with the length word
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_END;
                  rsp_char_in  = '0;
                  rsp_len_in   = len_ff;
                  rsp_last_in  = 1'b1;
                  if (clear_after_ff) begin
                     phase_in = PH_SEARCH;
                     match_in = '0;
                     len_in   = '0;
                  end
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_EMIT_OUT;
            end
         end

         ST_EMIT_OUT: begin
            // read address still holds idx, so the data stays put while stalled
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_CHAR;
               rsp_char_in  = ram_rd_data;
               rsp_len_in   = '0;
               rsp_last_in  = 1'b0;
               idx_in       = idx_ff + LEN_W'(1);
               state_in     = ST_EMIT_RD;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= PH_SEARCH;
         match_ff       <= '0;
         len_ff         <= '0;
         idx_ff         <= '0;
         clear_after_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         match_ff       <= match_in;
         len_ff         <= len_in;
         idx_ff         <= idx_in;
         clear_after_ff <= clear_after_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_char_ff <= rsp_char_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - LEN_W - CHAR_W)'(0), rsp_len_ff, rsp_char_ff};

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - title line extractor testbench
// Drives a byte stream with start and finish ops into the extractor and
// predicts every accept, title character and end word from a software copy
// of the keyword scanner and title store. Starts with a directed table that
// covers keyword fallback, leading filler, trailing trim, zero and 0xFF
// bytes, data after line end and the unused op. Then it plays random title
// jobs: mostly well formed keyword lines, plus broken keywords and noise.
// Both sides idle at random, and the receiver once holds off long enough
// to back up the input.
// ----------------------------------------------------------------------------
module tb_top;
   import dtle_pkg::*;

   localparam int HALF_PERIOD     = 10;
   localparam int RESET_CYCLES    = 9;
   localparam int RAND_WORDS      = 450;
   localparam int DRAIN_CYCLES    = 150;     // longest trim + emit walk, with margin
   localparam int LONG_HOLD       = 300;
   localparam int WATCHDOG_CYCLES = 2_000_000;

   // one expected output word
   typedef struct {
      kind_type               kind;
      char_type               ch;
      logic [LEN_W-1:0]       len;
      logic                   last;
   } title_word_type;

   // one input word
   typedef struct {
      op_type                 op;
      char_type               b;
   } stim_word_type;

   // directed row; when typed is set the single expected word is given here
   typedef struct {
      op_type                 op;
      char_type               b;
      bit                     typed;
      kind_type               kind;
      logic [LEN_W-1:0]       len;
   } dir_row_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic [CHAR_W-1:0]       req_tdata  = '0;
   logic [OP_W-1:0]         req_tuser  = OP_NONE;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [KIND_W-1:0]       rsp_tuser;
   logic                    rsp_tlast;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;

   // expected words, oldest first
   title_word_type          title_words_due[$];

   // software copy of the scanner
   phase_type               scan_ph;
   int                      key_hits;
   char_type                held[TITLE_CHARS];
   int                      held_len;

   int                      errors      = 0;
   int                      words_sent  = 0;
   int                      words_seen  = 0;
   int                      title_runs  = 0;
   int                      full_titles = 0;
   bit                      sink_hold_req = 1'b0;

   // "%%%Title: (\"\t" then A, 0x00, 0xFF, ") " and CR: keyword found after
   // an extra percent, filler skipped, trailing paren and blank trimmed
   dir_row_type dir_rows [25] = '{
      '{OP_FINISH, 8'h00,     1'b1, KIND_END,    6'd0},  // empty title at reset
      '{OP_DATA,   8'h00,     1'b1, KIND_ACCEPT, 6'd0},
      '{OP_DATA,   8'hFF,     1'b1, KIND_ACCEPT, 6'd0},
      '{OP_NONE,   8'hFF,     1'b1, KIND_ACCEPT, 6'd0},  // unused op ignored
      '{OP_DATA,   8'h25,     1'b1, KIND_ACCEPT, 6'd0},  // '%'
      '{OP_DATA,   8'h25,     1'b1, KIND_ACCEPT, 6'd0},
      '{OP_DATA,   8'h25,     1'b1, KIND_ACCEPT, 6'd0},  // third '%' falls back
      '{OP_DATA,   8'h54,     1'b0, KIND_ACCEPT, 6'd0},  // 'T'
      '{OP_DATA,   8'h69,     1'b0, KIND_ACCEPT, 6'd0},  // 'i'
      '{OP_DATA,   8'h74,     1'b0, KIND_ACCEPT, 6'd0},  // 't'
      '{OP_DATA,   8'h6C,     1'b0, KIND_ACCEPT, 6'd0},  // 'l'
      '{OP_DATA,   8'h65,     1'b0, KIND_ACCEPT, 6'd0},  // 'e'
      '{OP_DATA,   8'h3A,     1'b0, KIND_ACCEPT, 6'd0},  // ':'
      '{OP_DATA,   CH_SPACE,  1'b0, KIND_ACCEPT, 6'd0},
      '{OP_DATA,   CH_LPAREN, 1'b0, KIND_ACCEPT, 6'd0},
      '{OP_DATA,   CH_QUOTE,  1'b0, KIND_ACCEPT, 6'd0},
      '{OP_DATA,   CH_TAB,    1'b0, KIND_ACCEPT, 6'd0},
      '{OP_DATA,   8'h41,     1'b0, KIND_ACCEPT, 6'd0},  // 'A'
      '{OP_DATA,   8'h00,     1'b0, KIND_ACCEPT, 6'd0},  // zero byte is a character
      '{OP_DATA,   8'hFF,     1'b0, KIND_ACCEPT, 6'd0},
      '{OP_DATA,   CH_RPAREN, 1'b0, KIND_ACCEPT, 6'd0},
      '{OP_DATA,   CH_SPACE,  1'b0, KIND_ACCEPT, 6'd0},
      '{OP_DATA,   CH_CR,     1'b0, KIND_ACCEPT, 6'd0},  // line end: trimmed run
      '{OP_DATA,   8'h78,     1'b1, KIND_ACCEPT, 6'd0},  // ignored after line end
      '{OP_START,  8'h00,     1'b1, KIND_ACCEPT, 6'd0}
   };

   dsc_title_line_extractor_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic void clear_scan();
      scan_ph  = PH_SEARCH;
      key_hits = 0;
      held_len = 0;
   endfunction

   // title characters in order, then the end word carrying the length
   function automatic void push_title_run(ref title_word_type words[$]);
      for (int i = 0; i < held_len; i++) begin
         words.push_back('{KIND_CHAR, held[i], '0, 1'b0});
      end
      words.push_back('{KIND_END, 8'h00, LEN_W'(held_len), 1'b1});
   endfunction

   function automatic void predict_title_words(input op_type op, input char_type b,
                                               ref title_word_type words[$]);
      int k;
      case (op)
         OP_START: begin
            clear_scan();
         end
         OP_FINISH: begin
            // emit as held; trimmed only if the line already ended
            push_title_run(words);
            clear_scan();
            return;
         end
         OP_DATA: begin
            if (scan_ph == PH_SEARCH) begin
               // prefix match with fallback, so a run of '%' still finds the key
               k = (key_hits >= KEY_LEN) ? 0 : key_hits;
               while (k > 0 && b != KEY_BYTES[k]) k = int'(KEY_FAIL[k-1]);
               if (b == KEY_BYTES[k]) k++;
               if (k >= KEY_LEN) begin
                  scan_ph = PH_COLLECT;
                  k = 0;
               end
               key_hits = k;
            end else if (scan_ph == PH_COLLECT) begin
               if (b == CH_CR || b == CH_LF) begin
                  scan_ph = PH_DONE;
                  while (held_len > 0 && (held[held_len-1] == CH_SPACE ||
                         held[held_len-1] == CH_RPAREN || held[held_len-1] == CH_QUOTE))
                     held_len--;
                  push_title_run(words);
                  return;
               end
               // drop leading filler; drop overflow past capacity
               if (held_len == 0 && (b == CH_SPACE || b == CH_TAB ||
                                     b == CH_LPAREN || b == CH_QUOTE)) begin
               end else if (held_len < TITLE_CHARS) begin
                  held[held_len] = b;
                  held_len++;
               end
            end
         end
         default: begin
         end
      endcase
      words.push_back('{KIND_ACCEPT, 8'h00, '0, 1'b1});
   endfunction

   // ---------------------------------------------------------------------
   // Request side: optional gap, then hold the word until it is taken.
   // Valid is only lowered when a gap follows, so it never toggles twice
   // in one step.
   // ---------------------------------------------------------------------
   task automatic send_word(input op_type op, input char_type b, input bit quiet);
      int r;
      int gap;
      r   = $urandom_range(0, 99);
      gap = 0;
      if (!quiet) begin
         if (r >= 90) gap = $urandom_range(8, 30);
         else if (r >= 60) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= op;
      req_tdata  <= b;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // ---------------------------------------------------------------------
   // Response side: random ready pattern, with bursts of steady ready and,
   // on request, one long hold-off so the block backs up its input.
   // ---------------------------------------------------------------------
   initial begin : rsp_sink
      int r;
      int span;
      forever begin
         if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               rsp_tready <= 1'b1;
               span = $urandom_range(1, 6);
            end else if (r < 85) begin
               rsp_tready <= 1'b0;
               span = $urandom_range(1, 3);
            end else if (r < 95) begin
               rsp_tready <= 1'b1;
               span = $urandom_range(20, 60);
            end else begin
               rsp_tready <= 1'b0;
               span = $urandom_range(8, 30);
            end
            repeat (span) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Checker: compare each taken word against the oldest expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      title_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         words_seen++;
         if (title_words_due.size() == 0) begin
            $error("unexpected word: kind %0d char_out %0h title_len %0d last %0b",
                   rsp_tuser, rsp_tdata[7:0], rsp_tdata[13:8], rsp_tlast);
            errors++;
         end else begin
            want = title_words_due.pop_front();
            if (want.kind == KIND_END) begin
               title_runs++;
               if (want.len == LEN_W'(TITLE_CHARS)) full_titles++;
            end
            if (rsp_tuser !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[7:0] !== want.ch) begin
               $error("char_out: expected %0h, got %0h", want.ch, rsp_tdata[7:0]);
               errors++;
            end
            if (rsp_tdata[13:8] !== want.len) begin
               $error("title_len: expected %0d, got %0d", want.len, rsp_tdata[13:8]);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus: directed table, then random title jobs.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      title_word_type scratch[$];
      stim_word_type  job[$];
      int             rand_sent;
      int             n;
      int             r;
      int             key_take;
      bit             quiet;
      bit             force_long;
      bit             hold_done;
      bit             pause_done;
      char_type       c;

      rand_sent  = 0;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      clear_scan();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: typed rows carry their own single expected word
      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].op, dir_rows[i].b, 1'b0);
         scratch.delete();
         predict_title_words(dir_rows[i].op, dir_rows[i].b, scratch);
         if (dir_rows[i].typed) begin
            title_words_due.push_back('{dir_rows[i].kind, 8'h00, dir_rows[i].len, 1'b1});
         end else begin
            foreach (scratch[j]) title_words_due.push_back(scratch[j]);
         end
      end

      // drain before the random part
      req_tvalid <= 1'b0;
      while (title_words_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      while (rand_sent < RAND_WORDS) begin
         job.delete();
         quiet      = ($urandom_range(0, 3) == 0);
         force_long = 1'b0;

         // one long receiver hold-off while this job streams in back to back
         if (!hold_done && rand_sent >= 120) begin
            hold_done     = 1'b1;
            quiet         = 1'b1;
            force_long    = 1'b1;
            sink_hold_req = 1'b1;
         end

         // one sender pause until every expected word is back
         if (!pause_done && rand_sent >= 300) begin
            pause_done = 1'b1;
            req_tvalid <= 1'b0;
            while (title_words_due.size() != 0) @(posedge clock);
            repeat (DRAIN_CYCLES) @(posedge clock);
         end

         r = $urandom_range(0, 9);
         if (r < 2 && !force_long) begin
            // noise: any op, any byte
            n = $urandom_range(1, 8);
            repeat (n) job.push_back('{op_type'($urandom_range(0, 3)),
                                       char_type'($urandom_range(0, 255))});
         end else begin
            if ($urandom_range(0, 1))
               job.push_back('{OP_START, char_type'($urandom_range(0, 255))});
            n = $urandom_range(0, 4);
            repeat (n) job.push_back('{OP_DATA, char_type'($urandom_range(0, 255))});

            if (!force_long && $urandom_range(0, 5) == 0) begin
               // broken keyword: a true prefix, then a stray byte
               key_take = $urandom_range(1, KEY_LEN - 1);
               for (int i = 0; i < key_take; i++) job.push_back('{OP_DATA, KEY_BYTES[i]});
               job.push_back('{OP_DATA, char_type'($urandom_range(0, 255))});
            end else begin
               if ($urandom_range(0, 2) == 0) job.push_back('{OP_DATA, KEY_BYTES[0]});
               for (int i = 0; i < KEY_LEN; i++) job.push_back('{OP_DATA, KEY_BYTES[i]});

               // leading filler
               n = $urandom_range(0, 3);
               repeat (n) begin
                  case ($urandom_range(0, 3))
                     0:       c = CH_SPACE;
                     1:       c = CH_TAB;
                     2:       c = CH_LPAREN;
                     default: c = CH_QUOTE;
                  endcase
                  job.push_back('{OP_DATA, c});
               end

               // title body: mostly short, a few past capacity
               r = $urandom_range(0, 99);
               if (force_long)  n = 40;
               else if (r < 10) n = $urandom_range(30, 40);
               else             n = $urandom_range(0, 12);
               repeat (n) begin
                  r = $urandom_range(0, 99);
                  if (r < 70) begin
                     c = char_type'($urandom_range(8'h20, 8'h7E));
                  end else if (r < 85) begin
                     case ($urandom_range(0, 2))
                        0:       c = CH_SPACE;
                        1:       c = CH_RPAREN;
                        default: c = CH_QUOTE;
                     endcase
                  end else begin
                     c = char_type'($urandom_range(0, 255));
                  end
                  job.push_back('{OP_DATA, c});
               end

               // close the line, or finish mid-line (untrimmed)
               r = $urandom_range(0, 99);
               if (r < 45)      job.push_back('{OP_DATA, CH_CR});
               else if (r < 80) job.push_back('{OP_DATA, CH_LF});
               else             job.push_back('{OP_FINISH, char_type'($urandom_range(0, 255))});
            end

            n = $urandom_range(0, 2);
            repeat (n) job.push_back('{OP_DATA, char_type'($urandom_range(0, 255))});
            if ($urandom_range(0, 1))
               job.push_back('{OP_FINISH, char_type'($urandom_range(0, 255))});
         end

         foreach (job[i]) begin
            send_word(job[i].op, job[i].b, quiet);
            predict_title_words(job[i].op, job[i].b, title_words_due);
            rand_sent++;
         end
      end

      // let everything drain, then allow the block to settle
      req_tvalid <= 1'b0;
      while (title_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d words (%0d random); checked %0d output words",
               words_sent, rand_sent, words_seen);
      $display("in %0d title runs, %0d at full capacity.", title_runs, full_titles);
      if (errors == 0 && title_words_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // hard stop if the block hangs
   initial begin : watchdog
      #(2 * HALF_PERIOD * WATCHDOG_CYCLES);
      $error("timeout with %0d words still expected", title_words_due.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
